[sv/pite_pkg.sv]
// Package for the process ID table engine: codes, slot record and controller states.
package pite_pkg;

    localparam int ID_W     = 6;
    localparam int CODE_W   = 8;
    localparam int WST_W    = 10;
    localparam int STAT_W   = 3;
    localparam int ID_RANGE = 64;

    // Request codes
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_WAIT    = 2'd2;
    localparam logic [1:0] REQ_EXIT    = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_PROC    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_CHILD  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_EXITED = 3'd4;

    // Allocation starts here; slot 0 is never handed out
    localparam int FIRST_ID = 1;
    // Reaping walk on exit starts here
    localparam int REAP_FIRST_ID = 2;
    // This ID counts as a child of any waiter other than itself and its own parent
    localparam logic [ID_W-1:0] ALWAYS_CHILD_ID = 6'd2;

    // One table entry; the status is kept as the raw code, shifted on read
    typedef struct packed {
        logic [ID_W-1:0]   parent;
        logic              exited;
        logic [CODE_W-1:0] code;
    } slot_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREATE,
        S_DESTROY,
        S_WAIT_RC,
        S_WAIT_RT,
        S_WAIT_EV,
        S_EXIT_RC,
        S_EXIT_WR,
        S_EXIT_SCAN,
        S_EXIT_DRAIN,
        S_EXIT_PP,
        S_DONE
    } state_t;

endpackage

[sv/process_id_table_engine_core.sv]
// Process ID table engine: slot table memory, allocator, wait checks and exit reaping.
// Process ID table engine. Each request word (req_type, target_id, caller_id, parent_id,
// exit_code) gives exactly one result word (status, new_id, wait_status), in order. The
// table holds min(ID_SLOTS, 64) slots: a valid bit per slot in flip-flops cleared by reset,
// and parent, exited flag and exit code in a simple dual-port synchronous RAM (one read and
// one write port, read data registered). One request is worked at a time; req_stall is high
// from acceptance until the result has been moved into the output register. With
// N = min(ID_SLOTS, 64): create walks the valid bits from slot 1 upward, one slot per cycle,
// inspecting at most N - 1 slots; wait makes two RAM reads, caller then target; on exit the
// reaping walk reads one table entry per cycle through the RAM port from slot 2 to N - 1.
// A finished result waits in its own register, so the next request is taken while the
// previous result is still stalled downstream. The table needs no clearing pass: only the
// valid bits are reset, and an entry's data is used only while its valid bit is set, which
// only create does, as it writes the entry.
module process_id_table_engine_core #(
    parameter int ID_SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [pite_pkg::ID_W-1:0]     target_id,
    input  logic [pite_pkg::ID_W-1:0]     caller_id,
    input  logic [pite_pkg::ID_W-1:0]     parent_id,
    input  logic [pite_pkg::CODE_W-1:0]   exit_code,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [pite_pkg::STAT_W-1:0]   status,
    output logic [pite_pkg::ID_W-1:0]     new_id,
    output logic [pite_pkg::WST_W-1:0]    wait_status
);

    // Usable slots: IDs are 6 bits, so never more than 64
    localparam int LIM = (ID_SLOTS < pite_pkg::ID_RANGE) ? ID_SLOTS : pite_pkg::ID_RANGE;
    localparam int AW  = $clog2(LIM);
    localparam logic [pite_pkg::ID_W:0] LIM_W     = (pite_pkg::ID_W + 1)'(LIM);
    localparam logic [AW-1:0]           LAST_IDX  = AW'(LIM - 1);
    localparam logic [AW-1:0]           FIRST_IDX = AW'(pite_pkg::FIRST_ID);
    localparam logic [AW-1:0]           REAP_IDX  = AW'(pite_pkg::REAP_FIRST_ID);

    // ---------------------------------------------------------------- state
    pite_pkg::state_t state_reg, state_next;
    logic [LIM-1:0]   valid_reg, valid_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             chk_vld_reg, chk_vld_next;

    // request word held for the duration of the job
    logic [pite_pkg::ID_W-1:0]   target_reg, target_next;
    logic [pite_pkg::ID_W-1:0]   caller_reg, caller_next;
    logic [pite_pkg::ID_W-1:0]   parent_reg, parent_next;
    logic [pite_pkg::CODE_W-1:0] code_reg, code_next;
    logic [1:0]                  type_reg, type_next;

    // walk index (create search, exit scan) and the index whose read data is back
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;

    logic [pite_pkg::ID_W-1:0] cpar_reg, cpar_next;   // caller's parent (wait)
    logic [pite_pkg::ID_W-1:0] pp_reg, pp_next;       // caller's parent (exit)

    // pending result, then the output register
    logic [pite_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [pite_pkg::ID_W-1:0]   res_new_id_reg, res_new_id_next;
    logic [pite_pkg::WST_W-1:0]  res_wst_reg, res_wst_next;
    logic [pite_pkg::STAT_W-1:0] status_reg, status_next;
    logic [pite_pkg::ID_W-1:0]   new_id_reg, new_id_next;
    logic [pite_pkg::WST_W-1:0]  wst_reg, wst_next;

    // ---------------------------------------------------------------- table RAM
    pite_pkg::slot_entry_t slot_mem [LIM];
    pite_pkg::slot_entry_t rd_data_reg;
    pite_pkg::slot_entry_t mem_wdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[mem_raddr];
    end

    // ---------------------------------------------------------------- shared terms
    logic accept;
    logic out_free;
    logic target_live;
    logic caller_live;
    logic pp_live;
    logic create_hit;
    logic reap_hit;

    assign accept   = req_valid && (state_reg == pite_pkg::S_IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // a live ID is in range and has its valid bit set
    assign target_live = ({1'b0, target_reg} < LIM_W) && valid_reg[target_reg[AW-1:0]];
    assign caller_live = ({1'b0, caller_reg} < LIM_W) && valid_reg[caller_reg[AW-1:0]];
    assign pp_live     = ({1'b0, pp_reg} < LIM_W) && valid_reg[pp_reg[AW-1:0]];

    assign create_hit = !valid_reg[idx_reg];

    // exited child of the caller, seen in the cycle after its read was issued
    assign reap_hit = chk_vld_reg && valid_reg[chk_idx_reg]
                      && (rd_data_reg.parent == caller_reg) && rd_data_reg.exited;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pite_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_type)
                        pite_pkg::REQ_CREATE:  state_next = pite_pkg::S_CREATE;
                        pite_pkg::REQ_DESTROY: state_next = pite_pkg::S_DESTROY;
                        pite_pkg::REQ_WAIT:    state_next = pite_pkg::S_WAIT_RC;
                        pite_pkg::REQ_EXIT:    state_next = pite_pkg::S_EXIT_RC;
                        default:               state_next = pite_pkg::S_IDLE;
                    endcase
                end
            end
            pite_pkg::S_CREATE:
            begin
                if (create_hit || (idx_reg == LAST_IDX))
                begin
                    state_next = pite_pkg::S_DONE;
                end
            end
            pite_pkg::S_DESTROY:    state_next = pite_pkg::S_DONE;
            pite_pkg::S_WAIT_RC:    state_next = pite_pkg::S_WAIT_RT;
            pite_pkg::S_WAIT_RT:    state_next = pite_pkg::S_WAIT_EV;
            pite_pkg::S_WAIT_EV:    state_next = pite_pkg::S_DONE;
            pite_pkg::S_EXIT_RC:
            begin
                state_next = caller_live ? pite_pkg::S_EXIT_WR : pite_pkg::S_DONE;
            end
            pite_pkg::S_EXIT_WR:    state_next = pite_pkg::S_EXIT_SCAN;
            pite_pkg::S_EXIT_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = pite_pkg::S_EXIT_DRAIN;
                end
            end
            pite_pkg::S_EXIT_DRAIN: state_next = pite_pkg::S_EXIT_PP;
            pite_pkg::S_EXIT_PP:    state_next = pite_pkg::S_DONE;
            pite_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pite_pkg::S_IDLE;
                end
            end
            default:                state_next = pite_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath / outputs
    always_comb
    begin
        valid_next      = valid_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = idx_reg;
        idx_next        = idx_reg;
        target_next     = target_reg;
        caller_next     = caller_reg;
        parent_next     = parent_reg;
        code_next       = code_reg;
        type_next       = type_reg;
        cpar_next       = cpar_reg;
        pp_next         = pp_reg;
        res_status_next = res_status_reg;
        res_new_id_next = res_new_id_reg;
        res_wst_next    = res_wst_reg;
        status_next     = status_reg;
        new_id_next     = new_id_reg;
        wst_next        = wst_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        mem_raddr       = idx_reg;

        case (state_reg)
            pite_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    target_next     = target_id;
                    caller_next     = caller_id;
                    parent_next     = parent_id;
                    code_next       = exit_code;
                    type_next       = req_type;
                    idx_next        = FIRST_IDX;
                    res_status_next = pite_pkg::STAT_OK;
                    res_new_id_next = '0;
                    res_wst_next    = '0;
                end
            end
            pite_pkg::S_CREATE:
            begin
                if (create_hit)
                begin
                    valid_next[idx_reg] = 1'b1;
                    mem_we              = 1'b1;
                    mem_waddr           = idx_reg;
                    mem_wdata.parent    = parent_reg;
                    mem_wdata.exited    = 1'b0;
                    mem_wdata.code      = '0;
                    res_status_next     = pite_pkg::STAT_OK;
                    res_new_id_next     = pite_pkg::ID_W'(idx_reg);
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_status_next = pite_pkg::STAT_NO_FREE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pite_pkg::S_DESTROY:
            begin
                // out-of-range targets are ignored, result is ok regardless
                if ({1'b0, target_reg} < LIM_W)
                begin
                    valid_next[target_reg[AW-1:0]] = 1'b0;
                end
            end
            pite_pkg::S_WAIT_RC:
            begin
                mem_raddr = caller_reg[AW-1:0];
            end
            pite_pkg::S_WAIT_RT:
            begin
                cpar_next = rd_data_reg.parent;
                mem_raddr = target_reg[AW-1:0];
            end
            pite_pkg::S_WAIT_EV:
            begin
                // read data now holds the target's entry
                if (!target_live)
                begin
                    res_status_next = pite_pkg::STAT_NO_PROC;
                end
                else if ((caller_reg == target_reg)
                         || (caller_live && (cpar_reg == target_reg)))
                begin
                    res_status_next = pite_pkg::STAT_NOT_CHILD;
                end
                else if ((target_reg != pite_pkg::ALWAYS_CHILD_ID)
                         && (rd_data_reg.parent != caller_reg))
                begin
                    res_status_next = pite_pkg::STAT_NOT_CHILD;
                end
                else if (!rd_data_reg.exited)
                begin
                    res_status_next = pite_pkg::STAT_NOT_EXITED;
                end
                else
                begin
                    res_wst_next = {rd_data_reg.code, 2'b00};
                end
            end
            pite_pkg::S_EXIT_RC:
            begin
                mem_raddr = caller_reg[AW-1:0];
                if (!caller_live)
                begin
                    res_status_next = pite_pkg::STAT_NO_PROC;
                end
            end
            pite_pkg::S_EXIT_WR:
            begin
                // mark caller exited before the walk reads it back
                pp_next          = rd_data_reg.parent;
                mem_we           = 1'b1;
                mem_waddr        = caller_reg[AW-1:0];
                mem_wdata.parent = rd_data_reg.parent;
                mem_wdata.exited = 1'b1;
                mem_wdata.code   = code_reg;
                idx_next         = REAP_IDX;
            end
            pite_pkg::S_EXIT_SCAN:
            begin
                mem_raddr    = idx_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = idx_reg;
                if (reap_hit)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pite_pkg::S_EXIT_DRAIN:
            begin
                mem_raddr = pp_reg[AW-1:0];
                if (reap_hit)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
            end
            pite_pkg::S_EXIT_PP:
            begin
                // caller survives only under a live, not yet exited parent
                if (!(pp_live && !rd_data_reg.exited))
                begin
                    valid_next[caller_reg[AW-1:0]] = 1'b0;
                end
            end
            pite_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    new_id_next    = res_new_id_reg;
                    wst_next       = res_wst_reg;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pite_pkg::S_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        caller_reg     <= caller_next;
        parent_reg     <= parent_next;
        code_reg       <= code_next;
        type_reg       <= type_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        cpar_reg       <= cpar_next;
        pp_reg         <= pp_next;
        res_status_reg <= res_status_next;
        res_new_id_reg <= res_new_id_next;
        res_wst_reg    <= res_wst_next;
        status_reg     <= status_next;
        new_id_reg     <= new_id_next;
        wst_reg        <= wst_next;
    end

    assign req_stall   = (state_reg != pite_pkg::S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign new_id      = new_id_reg;
    assign wait_status = wst_reg;

    // ---------------------------------------------------------------- assertions
    // slot 0 is never allocated
    a_slot0_free: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0])
        else $error("slot 0 became valid");

    // a new result is only loaded from the finishing state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == pite_pkg::S_DONE))
        else $error("result loaded outside finishing state");

    // a nonzero new ID only comes with an ok status and no wait status
    a_new_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (new_id != '0)) |-> ((status == pite_pkg::STAT_OK)
                                           && (wait_status == '0)))
        else $error("new ID reported on a non-create result");

    // an allocation hit leaves the slot valid
    a_create_sets: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pite_pkg::S_CREATE) && create_hit) |=> valid_reg[$past(idx_reg)])
        else $error("allocated slot not marked valid");

    // the reaping walk never visits slots below the first reapable ID
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pite_pkg::S_EXIT_SCAN) |-> (idx_reg >= REAP_IDX))
        else $error("exit scan index below reap start");

    // the request type is held unchanged while a request is in flight
    a_type_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != pite_pkg::S_IDLE) && (state_next != pite_pkg::S_IDLE))
        |=> $stable(type_reg))
        else $error("request type changed mid-request");

endmodule
